// ----- src/cpf_pkg.sv -----
// shared constants and types for the cylinder potential flow evaluator
// no dependencies; used by cpf_mul and cylinder_potential_flow_eval
`default_nettype none

package cpf_pkg;

  // default fraction width of the Q-format values
  localparam int FRAC_BITS_DEF = 16;

  // operand slice width of one partial product
  localparam int CHUNK = 32;

  // configuration port
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_SPEED    = 3'd2,
    REG_DIAMETER = 3'd3
  } reg_idx_t;

  localparam logic [31:0] SPEED_RST = 32'h0001_0000;
  localparam logic [30:0] DIAM_RST  = 31'h0001_0000;

  // per-transaction side information that rides along the pipeline
  typedef struct packed {
    logic vld;
    logic in_body;
    logic rzero;
    logic neg_x;
    logic neg_y;
    logic neg_s;
  } tag_t;

endpackage

`default_nettype wire

// ----- src/cylinder_potential_flow_eval.sv -----
// top level of the cylinder potential flow evaluator: config registers,
// operand stages, divider lanes and output saturation; uses cpf_pkg, cpf_mul
`default_nettype none

// One query point enters per clock and one result leaves per transaction,
// in order. busy is always low and the receiver cannot stall, so the whole
// pipeline advances every cycle. The pipeline depth is set by two
// multiplier chains (4 and 9 stages, one 32x32 partial product each), and
// by the 33-step restoring divider (an overflow check, then one quotient
// bit per step) that all three results share in structure. Configuration
// writes take effect at once but must be made with no transaction in
// flight; the derived operands (|U0|, D*D, |U0|*D*D) settle well before a
// new point needs them.

module cylinder_potential_flow_eval #(
  parameter int FRAC_BITS = cpf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic                          cfg_wr_en,
  input  logic [cpf_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cpf_pkg::DATA_W-1:0]    cfg_data,
  output logic                          out_valid,
  output logic signed [31:0]            out_velocity_x,
  output logic signed [31:0]            out_velocity_y,
  output logic signed [31:0]            out_stream_value,
  output logic                          out_inside_body,
  output logic                          out_saturated
);

  localparam int C     = cpf_pkg::CHUNK;
  localparam int AMW   = 33;              // |point - center|
  localparam int SQW   = 2 * AMW;         // squares and products of magnitudes
  localparam int RW    = SQW;             // r2 = dx^2 + dy^2 fits the same width
  localparam int RRW   = 2 * RW;
  localparam int DFW   = 65;              // |dx^2 - dy^2|
  localparam int ADW   = RW + 2;          // |4 r2 - D^2|
  localparam int DDW   = 62;
  localparam int PW    = 32 + DDW;        // |U0| * D^2
  localparam int QW    = 32;
  localparam int L_SQ  = ((AMW + C - 1) / C) * ((AMW + C - 1) / C);
  // all four wide products below take three by three chunks
  localparam int L_BIG = ((PW + C - 1) / C) * ((DFW + C - 1) / C);
  localparam int DNW   = (RW + 2 + FRAC_BITS > RRW + 2) ? (RW + 2 + FRAC_BITS) : (RRW + 2);
  localparam int DW    = DNW + QW + 1;
  localparam int LAT   = 1 + 1 + L_SQ + 1 + L_BIG + QW + 1 + 1;

  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  assign busy = 1'b0;

  // ---------------------------------------------------------------- config
  logic signed [31:0] cx_r, cy_r, u0_r;
  logic [30:0]        diam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      u0_r   <= cpf_pkg::SPEED_RST;
      diam_r <= cpf_pkg::DIAM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cpf_pkg::REG_CENTER_X: cx_r   <= cfg_data;
        cpf_pkg::REG_CENTER_Y: cy_r   <= cfg_data;
        cpf_pkg::REG_SPEED:    u0_r   <= cfg_data;
        cpf_pkg::REG_DIAMETER: diam_r <= cfg_data[30:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // derived config operands, recomputed every cycle
  logic [31:0]    um_r;
  logic [DDW-1:0] dd_r;
  logic [PW-1:0]  p_w;

  always_ff @(posedge clk) begin
    um_r <= u0_r[31] ? 32'(-u0_r) : 32'(u0_r);
    dd_r <= DDW'(diam_r) * DDW'(diam_r);
  end

  cpf_mul #(.AW(32), .BW(DDW)) u_mul_p (.clk(clk), .a(um_r), .b(dd_r), .p(p_w));

  // ---------------------------------------------------------- input stage
  logic               v0_r;
  logic signed [31:0] x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start;
  end

  always_ff @(posedge clk) begin
    x0_r <= in_point_x;
    y0_r <= in_point_y;
  end

  // ------------------------------------------- offsets and their magnitudes
  logic signed [AMW-1:0] dx_w, dy_w;
  logic [AMW-1:0]        am_r, bm_r;
  logic                  an_r, bn_r, v1_r;

  assign dx_w = AMW'(x0_r) - AMW'(cx_r);
  assign dy_w = AMW'(y0_r) - AMW'(cy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    am_r <= dx_w[AMW-1] ? AMW'(-dx_w) : AMW'(dx_w);
    bm_r <= dy_w[AMW-1] ? AMW'(-dy_w) : AMW'(dy_w);
    an_r <= dx_w[AMW-1];
    bn_r <= dy_w[AMW-1];
  end

  // ------------------------------------------------------ squares, products
  logic [SQW-1:0] sa_w, sb_w, ab_w, ub_w;

  cpf_mul #(.AW(AMW), .BW(AMW)) u_mul_aa (.clk(clk), .a(am_r), .b(am_r), .p(sa_w));
  cpf_mul #(.AW(AMW), .BW(AMW)) u_mul_bb (.clk(clk), .a(bm_r), .b(bm_r), .p(sb_w));
  cpf_mul #(.AW(AMW), .BW(AMW)) u_mul_ab (.clk(clk), .a(am_r), .b(bm_r), .p(ab_w));
  cpf_mul #(.AW(AMW), .BW(AMW)) u_mul_ub (.clk(clk), .a(AMW'(um_r)), .b(bm_r), .p(ub_w));

  // valid and offset signs alongside the square multipliers
  logic [2:0] sq_dly_r [L_SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L_SQ; i++) sq_dly_r[i] <= '0;
    end else begin
      sq_dly_r[0] <= {v1_r, an_r, bn_r};
      for (int i = 1; i < L_SQ; i++) sq_dly_r[i] <= sq_dly_r[i-1];
    end
  end

  // ------------------------------------ r2, body test, numerator operands
  logic [RW-1:0]    r_w, dsq_w;
  logic [RW+1:0]    r4_w, dd4_w;
  logic             lt_w, inside_w, below_w, an2_w, bn2_w;
  cpf_pkg::tag_t    tag_w;

  logic [RW-1:0]    r_r;
  logic [DFW-1:0]   diff_r;
  logic [SQW-1:0]   ab_r, ub_r;
  logic [ADW-1:0]   absd_r;
  cpf_pkg::tag_t    tag2_r;

  assign an2_w    = sq_dly_r[L_SQ-1][1];
  assign bn2_w    = sq_dly_r[L_SQ-1][0];
  assign r_w      = sa_w + sb_w;
  assign r4_w     = {r_w, 2'b00};
  assign dd4_w    = (RW+2)'(dd_r);
  assign lt_w     = sa_w < sb_w;
  assign dsq_w    = lt_w ? (sb_w - sa_w) : (sa_w - sb_w);
  assign inside_w = r4_w <= dd4_w;
  assign below_w  = r4_w < dd4_w;

  always_comb begin
    tag_w.vld     = sq_dly_r[L_SQ-1][2];
    tag_w.in_body = inside_w;
    tag_w.rzero   = (r_w == '0);
    tag_w.neg_x   = u0_r[31] ^ lt_w;
    tag_w.neg_y   = ~(u0_r[31] ^ an2_w ^ bn2_w);
    tag_w.neg_s   = u0_r[31] ^ bn2_w ^ below_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tag2_r <= '0;
    else        tag2_r <= tag_w;
  end

  always_ff @(posedge clk) begin
    r_r    <= r_w;
    diff_r <= dsq_w[DFW-1:0];
    ab_r   <= ab_w;
    ub_r   <= ub_w;
    absd_r <= below_w ? (dd4_w - r4_w) : (r4_w - dd4_w);
  end

  // ---------------------------------------------- wide products
  logic [RRW-1:0]      rr_w;
  logic [PW+DFW-1:0]   n1_w;
  logic [PW+SQW-1:0]   n2_w;
  logic [SQW+ADW-1:0]  n3_w;

  cpf_mul #(.AW(RW),  .BW(RW))  u_mul_rr (.clk(clk), .a(r_r),  .b(r_r),    .p(rr_w));
  cpf_mul #(.AW(PW),  .BW(DFW)) u_mul_n1 (.clk(clk), .a(p_w),  .b(diff_r), .p(n1_w));
  cpf_mul #(.AW(PW),  .BW(SQW)) u_mul_n2 (.clk(clk), .a(p_w),  .b(ab_r),   .p(n2_w));
  cpf_mul #(.AW(SQW), .BW(ADW)) u_mul_n3 (.clk(clk), .a(ub_r), .b(absd_r), .p(n3_w));

  cpf_pkg::tag_t tb_r [L_BIG];
  logic [RW-1:0] rb_r [L_BIG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L_BIG; i++) tb_r[i] <= '0;
    end else begin
      tb_r[0] <= tag2_r;
      for (int i = 1; i < L_BIG; i++) tb_r[i] <= tb_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    rb_r[0] <= r_r;
    for (int i = 1; i < L_BIG; i++) rb_r[i] <= rb_r[i-1];
  end

  // ------------------------------------------------ restoring dividers
  // lane 0: horizontal velocity, 1: vertical velocity, 2: stream function
  logic [DW-1:0]  num_in [3];
  logic [DNW-1:0] den_in [3];

  assign num_in[0] = DW'(n1_w);
  assign num_in[1] = DW'(n2_w);
  assign num_in[2] = DW'(n3_w);
  assign den_in[0] = DNW'({rr_w, 2'b00});
  assign den_in[1] = DNW'({rr_w, 1'b0});
  assign den_in[2] = DNW'(rb_r[L_BIG-1]) << (2 + FRAC_BITS);

  logic [DW-1:0]  rem_r [3][QW+1];
  logic [DNW-1:0] den_r [3][QW+1];
  logic [QW-1:0]  q_r   [3][QW+1];
  logic           ovf_r [3][QW+1];
  cpf_pkg::tag_t  td_r  [QW+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    // first step only flags a quotient that needs more than QW bits
    always_ff @(posedge clk) begin
      rem_r[l][0] <= num_in[l];
      den_r[l][0] <= den_in[l];
      q_r[l][0]   <= '0;
      ovf_r[l][0] <= num_in[l] >= (DW'(den_in[l]) << QW);
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
      localparam int K = QW - j;
      logic [DW-1:0] trial;
      logic          ge;

      assign trial = DW'(den_r[l][j-1]) << K;
      assign ge    = rem_r[l][j-1] >= trial;

      always_ff @(posedge clk) begin
        rem_r[l][j] <= ge ? (rem_r[l][j-1] - trial) : rem_r[l][j-1];
        den_r[l][j] <= den_r[l][j-1];
        q_r[l][j]   <= q_r[l][j-1] | (ge ? (QW'(1) << K) : '0);
        ovf_r[l][j] <= ovf_r[l][j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QW; i++) td_r[i] <= '0;
    end else begin
      td_r[0] <= tb_r[L_BIG-1];
      for (int i = 1; i <= QW; i++) td_r[i] <= td_r[i-1];
    end
  end

  // ------------------------------------------------ sign and saturation
  // returns {clipped, value} for a signed result given by magnitude and sign
  function automatic logic [32:0] clip_mag(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic [32:0] res;
    if (ovf || (q[QW-1] && (q[QW-2:0] != '0))) begin
      res = {1'b1, neg ? S_MIN : S_MAX};
    end else if (q == S_MIN) begin
      res = neg ? {1'b0, S_MIN} : {1'b1, S_MAX};
    end else begin
      res = {1'b0, neg ? 32'(-q) : q};
    end
    return res;
  endfunction

  cpf_pkg::tag_t      tf_w;
  logic [32:0]        cx_w, cy_w, cs_w;
  logic signed [33:0] vxd_w;
  logic [31:0]        vx_w, vy_w, ps_w;
  logic               satv_w, sats_w;

  assign tf_w = td_r[QW];
  assign cx_w = clip_mag(q_r[0][QW], ovf_r[0][QW], tf_w.neg_x);
  assign cy_w = clip_mag(q_r[1][QW], ovf_r[1][QW], tf_w.neg_y);
  assign cs_w = clip_mag(q_r[2][QW], ovf_r[2][QW], tf_w.neg_s);

  // horizontal velocity is U0 minus the perturbation term
  assign vxd_w = 34'(u0_r) - 34'(signed'(cx_w[31:0]));

  always_comb begin
    vx_w   = '0;
    vy_w   = '0;
    satv_w = 1'b0;
    if (!tf_w.in_body) begin
      priority if (vxd_w > 34'sd2147483647) begin
        vx_w   = S_MAX;
        satv_w = 1'b1;
      end else if (vxd_w < -34'sd2147483648) begin
        vx_w   = S_MIN;
        satv_w = 1'b1;
      end else begin
        vx_w = vxd_w[31:0];
      end
      vy_w   = cy_w[31:0];
      satv_w = satv_w | cx_w[32] | cy_w[32];
    end
  end

  // at the center the stream function runs off to the positive limit
  assign ps_w   = tf_w.rzero ? S_MAX : cs_w[31:0];
  assign sats_w = tf_w.rzero | cs_w[32];

  // ------------------------------------------------------- output register
  logic               out_valid_r;
  logic signed [31:0] vx_r, vy_r, ps_r;
  logic               inside_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= tf_w.vld;
  end

  always_ff @(posedge clk) begin
    vx_r     <= vx_w;
    vy_r     <= vy_w;
    ps_r     <= ps_w;
    inside_r <= tf_w.in_body;
    sat_r    <= satv_w | sats_w;
  end

  assign out_valid        = out_valid_r;
  assign out_velocity_x   = vx_r;
  assign out_velocity_y   = vy_r;
  assign out_stream_value = ps_r;
  assign out_inside_body  = inside_r;
  assign out_saturated    = sat_r;

`ifndef SYNTH
  // every accepted point comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing after fixed latency");

  // zero velocity inside the body
  a_inside_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_body) |-> (out_velocity_x == '0 && out_velocity_y == '0))
    else $error("nonzero velocity inside body");

  // velocity quotients are bounded by |U0| outside the body
  a_vel_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (td_r[QW].vld && !td_r[QW].in_body) |-> (!ovf_r[0][QW] && !ovf_r[1][QW]))
    else $error("velocity quotient overflow");

  // a point on the center gives a clipped stream value
  a_center_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (td_r[QW].vld && td_r[QW].rzero) |=> (out_saturated && out_stream_value == S_MAX))
    else $error("center point not saturated");
`endif

endmodule

`default_nettype wire

// ----- src/cpf_mul.sv -----
// pipelined unsigned multiplier built from chunk-by-chunk partial products
// depends on cpf_pkg (chunk width)
`default_nettype none

module cpf_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int C  = cpf_pkg::CHUNK;
  localparam int NA = (AW + C - 1) / C;
  localparam int NB = (BW + C - 1) / C;
  localparam int NS = NA * NB;
  localparam int AP = NA * C;
  localparam int BP = NB * C;
  localparam int PW = AP + BP;

  logic [AP-1:0] a_ext;
  logic [BP-1:0] b_ext;
  logic [AP-1:0] a_r   [NS];
  logic [BP-1:0] b_r   [NS];
  logic [PW-1:0] acc_r [NS];

  assign a_ext = AP'(a);
  assign b_ext = BP'(b);

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int IA = s % NA;
    localparam int IB = s / NA;
    logic [C-1:0]   ca;
    logic [C-1:0]   cb;
    logic [2*C-1:0] pp;
    logic [PW-1:0]  base;

    if (s == 0) begin : g_first
      assign ca   = a_ext[IA*C +: C];
      assign cb   = b_ext[IB*C +: C];
      assign base = '0;
      always_ff @(posedge clk) begin
        a_r[s] <= a_ext;
        b_r[s] <= b_ext;
      end
    end else begin : g_next
      assign ca   = a_r[s-1][IA*C +: C];
      assign cb   = b_r[s-1][IB*C +: C];
      assign base = acc_r[s-1];
      always_ff @(posedge clk) begin
        a_r[s] <= a_r[s-1];
        b_r[s] <= b_r[s-1];
      end
    end

    assign pp = ca * cb;

    // one partial product folded into the running sum per stage
    always_ff @(posedge clk) begin
      acc_r[s] <= base + (PW'(pp) << (C * (IA + IB)));
    end
  end

  assign p = acc_r[NS-1][AW+BW-1:0];

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for cylinder_potential_flow_eval: a queued driver,
// a strobe monitor and a wide-integer flow predictor; depends on cpf_pkg
`default_nettype none

module tb_top;

  // unused register indexes, writes there must be ignored
  localparam logic [cpf_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [cpf_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
  } query_t;

  typedef struct {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] stream;
    logic               in_body;
    logic               sat;
  } flow_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic cfg_wr_en = 1'b0;
  logic [cpf_pkg::IDX_W-1:0] cfg_index = '0;
  logic [cpf_pkg::DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [31:0] out_velocity_x, out_velocity_y, out_stream_value;
  logic out_inside_body, out_saturated;

  // predictor copy of the configuration registers
  longint  ctr_x = 0;
  longint  ctr_y = 0;
  longint  speed = 65536;
  longint  diam  = 65536;

  query_t    pending_points[$];
  flow_res_t expected_flow[$];
  int errors = 0;
  int checked = 0;
  int n_inside = 0;
  int n_sat = 0;
  int cycles = 0;
  int burst_left = 4;
  int gap_left = 0;

  cylinder_potential_flow_eval dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_velocity_x(out_velocity_x),
    .out_velocity_y(out_velocity_y), .out_stream_value(out_stream_value),
    .out_inside_body(out_inside_body), .out_saturated(out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip32(longint v, inout bit sat);
    if (v > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // signed value from a wide magnitude, clipped to 32 bits
  function automatic longint mag_to_s32(logic [255:0] mag, bit neg, inout bit sat);
    if (mag > 256'h8000_0000) begin
      sat = 1'b1;
      return neg ? S32_MIN : S32_MAX;
    end
    if (neg) return -longint'(mag[63:0]);
    return clip32(longint'(mag[63:0]), sat);
  endfunction

  // exact rational evaluation of u, v and psi at one query point
  function automatic flow_res_t flow_predict(query_t q);
    longint a, b, vx, vy, ps;
    logic [255:0] am, bm, um, sa, sb, rr, r4, dd, diff, quo;
    bit sat, in_body, neg, below;
    flow_res_t res;
    a = longint'(q.px) - ctr_x;
    b = longint'(q.py) - ctr_y;
    am = 256'(a < 0 ? -a : a);
    bm = 256'(b < 0 ? -b : b);
    um = 256'(speed < 0 ? -speed : speed);
    sa = am * am;
    sb = bm * bm;
    rr = sa + sb;
    r4 = rr << 2;
    dd = 256'(diam) * 256'(diam);
    sat = 1'b0;
    vx = 0;
    vy = 0;
    in_body = (r4 <= dd);
    if (!in_body) begin
      diff = (sa >= sb) ? sa - sb : sb - sa;
      neg = (speed < 0) != (sa < sb);
      quo = (um * dd * diff) / (rr * r4);
      vx = clip32(speed - mag_to_s32(quo, neg, sat), sat);
      neg = !((speed < 0) != ((a < 0) != (b < 0)));
      quo = (um * dd * am * bm) / ((rr * rr) << 1);
      vy = mag_to_s32(quo, neg, sat);
    end
    if (rr == 0) begin
      // query exactly at the centre: psi pinned to the top
      ps = S32_MAX;
      sat = 1'b1;
    end else begin
      below = (r4 < dd);
      neg = ((speed < 0) != (b < 0)) != below;
      diff = below ? dd - r4 : r4 - dd;
      quo = (um * bm * diff) / (r4 << cpf_pkg::FRAC_BITS_DEF);
      ps = mag_to_s32(quo, neg, sat);
    end
    res.vel_x = vx[31:0];
    res.vel_y = vy[31:0];
    res.stream = ps[31:0];
    res.in_body = in_body;
    res.sat = sat;
    return res;
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (start && !busy) begin
      expected_flow.push_back(flow_predict('{in_point_x, in_point_y}));
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_points.size() > 0 && !(start && busy)) begin
      query_t nxt;
      nxt = pending_points.pop_front();
      in_point_x <= nxt.px;
      in_point_y <= nxt.py;
      start <= 1'b1;
      if (burst_left <= 1) begin
        // occasional long stretch with no gaps at all
        burst_left <= $urandom_range(1, 16) * (($urandom_range(0, 7) == 0) ? 8 : 1);
        gap_left <= $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else if (!(start && busy)) begin
      start <= 1'b0;
    end
  end

  // monitor: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_flow.size() == 0) begin
        $display("%0t: unexpected result vx=%h vy=%h psi=%h", $time,
                 out_velocity_x, out_velocity_y, out_stream_value);
        errors++;
      end else begin
        flow_res_t exp_r;
        exp_r = expected_flow.pop_front();
        checked++;
        if (exp_r.in_body) n_inside++;
        if (exp_r.sat) n_sat++;
        if (out_velocity_x !== exp_r.vel_x) begin
          $display("%0t: velocity_x expected %h actual %h", $time, exp_r.vel_x,
                   out_velocity_x);
          errors++;
        end
        if (out_velocity_y !== exp_r.vel_y) begin
          $display("%0t: velocity_y expected %h actual %h", $time, exp_r.vel_y,
                   out_velocity_y);
          errors++;
        end
        if (out_stream_value !== exp_r.stream) begin
          $display("%0t: stream_value expected %h actual %h", $time, exp_r.stream,
                   out_stream_value);
          errors++;
        end
        if (out_inside_body !== exp_r.in_body) begin
          $display("%0t: inside_body expected %b actual %b", $time, exp_r.in_body,
                   out_inside_body);
          errors++;
        end
        if (out_saturated !== exp_r.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_r.sat,
                   out_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one register write, mirrored into the predictor copy
  task automatic reg_write(logic [cpf_pkg::IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      cpf_pkg::REG_CENTER_X: ctr_x = longint'(signed'(val));
      cpf_pkg::REG_CENTER_Y: ctr_y = longint'(signed'(val));
      cpf_pkg::REG_SPEED:    speed = longint'(signed'(val));
      cpf_pkg::REG_DIAMETER: diam = longint'({1'b0, val[30:0]});
      default: ;
    endcase
  endtask

  task automatic set_flow(logic [31:0] cx, logic [31:0] cy, logic [31:0] u,
                          logic [31:0] d);
    reg_write(cpf_pkg::REG_CENTER_X, cx);
    reg_write(cpf_pkg::REG_CENTER_Y, cy);
    reg_write(cpf_pkg::REG_SPEED, u);
    reg_write(cpf_pkg::REG_DIAMETER, d);
    // spare indexes must leave everything alone
    reg_write(logic'($urandom_range(0, 1)) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  task automatic add_point(longint x, longint y);
    query_t q;
    q.px = x[31:0];
    q.py = y[31:0];
    pending_points.push_back(q);
  endtask

  // offsets around the centre at body scale, at random scale or on an axis, or anywhere at all
  task automatic add_random_points(int n);
    longint sc, ox, oy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: add_point($urandom, $urandom);
        1: begin
          sc = (diam >> $urandom_range(0, 3)) + 1;
          ox = longint'($urandom_range(0, 32'hffff_fffe)) % (2 * sc + 1) - sc;
          oy = longint'($urandom_range(0, 32'hffff_fffe)) % (2 * sc + 1) - sc;
          add_point(ctr_x + ox, ctr_y + oy);
        end
        2: begin
          ox = longint'(signed'(32'($urandom))) >>> $urandom_range(0, 28);
          oy = longint'(signed'(32'($urandom))) >>> $urandom_range(0, 28);
          add_point(ctr_x + ox, ctr_y + oy);
        end
        default: begin
          // on an axis through the centre
          ox = longint'(signed'(32'($urandom))) >>> $urandom_range(8, 24);
          if ($urandom_range(0, 1)) add_point(ctr_x + ox, ctr_y);
          else add_point(ctr_x, ctr_y + ox);
        end
      endcase
    end
  endtask

  // let every queued transaction go in and every result come back
  task automatic drain;
    while (pending_points.size() > 0 || start || expected_flow.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, centre, boundary, diagonals, extremes
    add_point(0, 0);
    add_point(65536 / 2, 0);
    add_point(0, -65536 / 2);
    add_point(65536, 0);
    add_point(0, 65536);
    add_point(65536, 65536);
    add_point(-65536, 65536);
    add_point(S32_MAX, S32_MAX);
    add_point(S32_MIN, S32_MIN);
    add_point(S32_MIN, S32_MAX);
    add_point(1, 0);
    add_point(0, 1);
    drain();

    // wide body with extreme centre and speed
    set_flow(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    add_point(S32_MIN, S32_MAX);
    add_point(S32_MAX, S32_MIN);
    add_point(S32_MAX, S32_MAX);
    add_point(S32_MIN, S32_MIN);
    add_point(0, 0);
    add_random_points(120);
    drain();

    // zero diameter: inside only at the centre
    set_flow(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    add_point(S32_MIN, S32_MAX);
    add_point(S32_MIN + 1, S32_MAX);
    add_point(S32_MAX, S32_MIN);
    add_random_points(120);
    drain();

    // boundary of a two-unit body, zero speed
    set_flow(32'h0, 32'h0, 32'h0, 32'h0002_0000);
    add_point(65536, 0);
    add_point(65537, 0);
    add_point(0, -65536);
    add_random_points(100);
    drain();

    // random settings, mostly moderate sizes
    for (int ph = 0; ph < 7; ph++) begin
      set_flow($urandom, $urandom,
               (ph % 2) ? $urandom : 32'(signed'(32'($urandom)) >>> 12),
               (ph % 3 == 0) ? $urandom : ($urandom >> $urandom_range(8, 20)));
      add_random_points(110);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results across 11 register settings", checked);
    $display("%0d inside the body, %0d saturated", n_inside, n_sat);
    if (errors == 0 && expected_flow.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
